// File: rtl/core/crnr_pkg.sv
// Shared constants and types for the CAN register node responder.
package crnr_pkg;

    localparam int unsigned NUM_REGS   = 8;
    localparam int unsigned REG_W      = 8;
    localparam int unsigned IDX_W      = 3;
    localparam int unsigned ID_W       = 29;
    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned EXTRA_W    = 2;
    localparam int unsigned LEN_W      = 4;
    localparam int unsigned DATA_W     = 64;
    localparam int unsigned TX_LEN_W   = 3;
    localparam int unsigned TX_DATA_W  = 56;
    localparam int unsigned NUM_TX_REG = 7;
    localparam int unsigned OP_W       = 2;

    localparam int unsigned ID_SND_LSB = 21;
    localparam int unsigned ID_RCV_LSB = 13;
    localparam int unsigned ID_OP_LSB  = 11;
    localparam int unsigned ID_REG_LSB = 8;

    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [OP_W-1:0] OP_WRITE     = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_ACK = 2'd1;
    localparam logic [OP_W-1:0] OP_READ      = 2'd2;
    localparam logic [OP_W-1:0] OP_ACK       = 2'd3;

    localparam logic [IDX_W-1:0]    MULTI_REG  = 3'd7;
    localparam logic [IDX_W-1:0]    LAST_TX    = 3'd6;
    localparam logic [REG_W-1:0]    PAY_ALL    = 8'hFF;
    localparam logic [TX_LEN_W-1:0] TX_LEN_MUL = 3'd7;

    localparam logic [1:0] CFG_MY_ADDR = 2'd0;
    localparam logic [1:0] CFG_EXTRA   = 2'd1;
    localparam logic [1:0] CFG_BCAST   = 2'd2;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        logic [REG_W-1:0] wdata;
    } t_rf_req;

    typedef struct packed {
        logic [REG_W-1:0] rdata;
        logic             diff;
    } t_rf_rsp;

endpackage

// File: rtl/core/crnr_regfile.sv
// Register file with one shared compare and write port.
module crnr_regfile (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  crnr_pkg::t_rf_req                   i_req,
    output crnr_pkg::t_rf_rsp                   o_rsp,
    output logic [crnr_pkg::TX_DATA_W-1:0]      o_pack
);

    logic [crnr_pkg::REG_W-1:0] r_regs [crnr_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < int'(crnr_pkg::NUM_REGS); i++) begin
                r_regs[i] <= '0;
            end
        end else if (i_req.we) begin
            r_regs[i_req.idx] <= i_req.wdata;
        end
    end

    assign o_rsp.rdata = r_regs[i_req.idx];
    assign o_rsp.diff  = (r_regs[i_req.idx] != i_req.wdata);

    always_comb begin
        for (int i = 0; i < int'(crnr_pkg::NUM_TX_REG); i++) begin
            o_pack[i*crnr_pkg::REG_W +: crnr_pkg::REG_W] = r_regs[i];
        end
    end

endmodule

// File: rtl/core/can_register_node_responder.sv
// Top level of the CAN register node responder: filter, sequencer and reply builder.
//
// Each request is taken when the block is idle and walks a short sequencer:
// filter and capture, execute, build reply, deliver. A received write, write
// with ACK or read passes through all four steps before its result is loaded
// into the output register; a local write or read skips the build step, and a
// rejected frame, a received ACK or an unknown request goes from filter
// straight to deliver. A multi-register write (register 7) loops in execute,
// because the single register compare/write port steps over registers 0..6
// one per cycle. The next request is accepted the cycle after a result is
// loaded into the output register, even if that result has not been taken
// yet. A result still waiting in the output register holds the following one
// in the deliver step until it is taken.
module can_register_node_responder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_idx,
    input  logic [7:0]                          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_req_type,
    input  logic [crnr_pkg::ID_W-1:0]           i_frame_id,
    input  logic [crnr_pkg::LEN_W-1:0]          i_frame_len,
    input  logic [crnr_pkg::DATA_W-1:0]         i_frame_data,
    input  logic [crnr_pkg::IDX_W-1:0]          i_local_index,
    input  logic [crnr_pkg::REG_W-1:0]          i_local_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_accepted,
    output logic                                o_changed,
    output logic                                o_tx_valid,
    output logic [crnr_pkg::ID_W-1:0]           o_tx_id,
    output logic [crnr_pkg::TX_LEN_W-1:0]       o_tx_len,
    output logic [crnr_pkg::TX_DATA_W-1:0]      o_tx_data,
    output logic [crnr_pkg::REG_W-1:0]          o_read_value
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_EXEC,
        S_BUILD,
        S_DONE
    } t_state;

    t_state r_state;

    logic [crnr_pkg::ADDR_W-1:0]   r_my_addr;
    logic [crnr_pkg::EXTRA_W-1:0]  r_extra;
    logic [crnr_pkg::ADDR_W-1:0]   r_bcast;

    logic [1:0]                    r_req;
    logic [crnr_pkg::ID_W-1:0]     r_id;
    logic [crnr_pkg::LEN_W-1:0]    r_len;
    logic [crnr_pkg::DATA_W-1:0]   r_data;
    logic [crnr_pkg::IDX_W-1:0]    r_lidx;
    logic [crnr_pkg::REG_W-1:0]    r_lval;

    logic [crnr_pkg::REG_W-1:0]    r_lfb [crnr_pkg::NUM_REGS];
    logic [crnr_pkg::EXTRA_W-1:0]  r_active;
    logic [crnr_pkg::ADDR_W-1:0]   r_sender;
    logic [crnr_pkg::IDX_W-1:0]    r_cnt;

    logic                          r_acc;
    logic                          r_chg;
    logic                          r_txv;
    logic [crnr_pkg::ID_W-1:0]     r_txid;
    logic [crnr_pkg::TX_LEN_W-1:0] r_txlen;
    logic [crnr_pkg::TX_DATA_W-1:0] r_txdata;
    logic [crnr_pkg::REG_W-1:0]    r_rv;

    logic                          r_ov;
    logic                          r_o_acc;
    logic                          r_o_chg;
    logic                          r_o_txv;
    logic [crnr_pkg::ID_W-1:0]     r_o_txid;
    logic [crnr_pkg::TX_LEN_W-1:0] r_o_txlen;
    logic [crnr_pkg::TX_DATA_W-1:0] r_o_txdata;
    logic [crnr_pkg::REG_W-1:0]    r_o_rv;

    logic [crnr_pkg::ADDR_W-1:0]   w_snd;
    logic [crnr_pkg::ADDR_W-1:0]   w_rcv;
    logic [crnr_pkg::OP_W-1:0]     w_op;
    logic [crnr_pkg::IDX_W-1:0]    w_reg;
    logic [crnr_pkg::REG_W-1:0]    w_pay;
    logic [crnr_pkg::ADDR_W-1:0]   w_off;
    logic                          w_hit;
    logic                          w_is_wr;
    logic                          w_multi;
    logic [crnr_pkg::ADDR_W-1:0]   w_me;
    logic [crnr_pkg::REG_W-1:0]    w_txpay;
    logic                          w_out_free;

    crnr_pkg::t_rf_req             w_rf_req;
    crnr_pkg::t_rf_rsp             w_rf_rsp;
    logic [crnr_pkg::TX_DATA_W-1:0] w_pack;

    crnr_regfile u_regfile (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_rf_req),
        .o_rsp   (w_rf_rsp),
        .o_pack  (w_pack)
    );

    assign w_snd   = r_id[crnr_pkg::ID_SND_LSB +: crnr_pkg::ADDR_W];
    assign w_rcv   = r_id[crnr_pkg::ID_RCV_LSB +: crnr_pkg::ADDR_W];
    assign w_op    = r_id[crnr_pkg::ID_OP_LSB  +: crnr_pkg::OP_W];
    assign w_reg   = r_id[crnr_pkg::ID_REG_LSB +: crnr_pkg::IDX_W];
    assign w_pay   = r_id[crnr_pkg::REG_W-1:0];
    assign w_off   = w_rcv - r_my_addr;
    assign w_hit   = (w_snd == r_bcast) || (w_off <= {6'd0, r_extra});
    assign w_is_wr = (w_op == crnr_pkg::OP_WRITE) || (w_op == crnr_pkg::OP_WRITE_ACK);
    assign w_multi = (w_reg == crnr_pkg::MULTI_REG);
    assign w_me    = r_my_addr + {6'd0, r_active};
    assign w_txpay = !w_multi ? w_rf_rsp.rdata :
                     (w_op == crnr_pkg::OP_WRITE_ACK) ? w_pay : crnr_pkg::PAY_ALL;
    assign w_out_free = !r_ov || i_out_ready;

    always_comb begin
        w_rf_req.we    = 1'b0;
        w_rf_req.idx   = r_lidx;
        w_rf_req.wdata = r_lval;
        case (r_state)
            S_EXEC: begin
                if (r_req == crnr_pkg::REQ_WRITE) begin
                    w_rf_req.we = 1'b1;
                end else if (r_req == crnr_pkg::REQ_FRAME && w_is_wr) begin
                    if (w_multi) begin
                        w_rf_req.idx   = r_cnt;
                        w_rf_req.wdata = r_lfb[r_cnt];
                        w_rf_req.we    = w_pay[r_cnt];
                    end else begin
                        w_rf_req.idx   = w_reg;
                        w_rf_req.wdata = w_pay;
                        w_rf_req.we    = 1'b1;
                    end
                end
            end
            S_BUILD: begin
                w_rf_req.idx = w_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_my_addr <= '0;
            r_extra   <= '0;
            r_bcast   <= '0;
            r_active  <= '0;
            r_sender  <= '0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
            for (int i = 0; i < int'(crnr_pkg::NUM_REGS); i++) begin
                r_lfb[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    crnr_pkg::CFG_MY_ADDR: r_my_addr <= i_cfg_data;
                    crnr_pkg::CFG_EXTRA:   r_extra   <= i_cfg_data[crnr_pkg::EXTRA_W-1:0];
                    crnr_pkg::CFG_BCAST:   r_bcast   <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (r_ov && i_out_ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req    <= i_req_type;
                        r_id     <= i_frame_id;
                        r_len    <= i_frame_len;
                        r_data   <= i_frame_data;
                        r_lidx   <= i_local_index;
                        r_lval   <= i_local_value;
                        r_acc    <= 1'b0;
                        r_chg    <= 1'b0;
                        r_txv    <= 1'b0;
                        r_txid   <= '0;
                        r_txlen  <= '0;
                        r_txdata <= '0;
                        r_rv     <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_FILT;
                    end
                end
                S_FILT: begin
                    case (r_req)
                        crnr_pkg::REQ_FRAME: begin
                            if (w_hit) begin
                                r_acc <= 1'b1;
                                for (int i = 0; i < int'(crnr_pkg::NUM_REGS); i++) begin
                                    if (crnr_pkg::LEN_W'(i) < r_len) begin
                                        r_lfb[i] <= r_data[i*crnr_pkg::REG_W +: crnr_pkg::REG_W];
                                    end
                                end
                                r_active <= (w_off > {6'd0, r_extra}) ? r_extra
                                          : w_off[crnr_pkg::EXTRA_W-1:0];
                                r_sender <= w_snd;
                                r_state  <= (w_op == crnr_pkg::OP_ACK) ? S_DONE : S_EXEC;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        crnr_pkg::REQ_WRITE,
                        crnr_pkg::REQ_READ: r_state <= S_EXEC;
                        default:            r_state <= S_DONE;
                    endcase
                end
                S_EXEC: begin
                    if (r_req == crnr_pkg::REQ_WRITE) begin
                        r_chg   <= w_rf_rsp.diff;
                        r_state <= S_DONE;
                    end else if (r_req == crnr_pkg::REQ_READ) begin
                        r_rv    <= w_rf_rsp.rdata;
                        r_state <= S_DONE;
                    end else if (w_is_wr && w_multi) begin
                        if (w_rf_req.we && w_rf_rsp.diff) begin
                            r_chg <= 1'b1;
                        end
                        r_cnt <= r_cnt + 3'd1;
                        if (r_cnt == crnr_pkg::LAST_TX) begin
                            r_state <= S_BUILD;
                        end
                    end else begin
                        if (w_is_wr) begin
                            r_chg <= w_rf_rsp.diff;
                        end
                        r_state <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    if (w_op != crnr_pkg::OP_WRITE) begin
                        r_txv  <= 1'b1;
                        r_txid <= {w_me, r_sender, crnr_pkg::OP_ACK, w_reg, w_txpay};
                        if (w_multi) begin
                            r_txlen  <= crnr_pkg::TX_LEN_MUL;
                            r_txdata <= w_pack;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_ov       <= 1'b1;
                        r_o_acc    <= r_acc;
                        r_o_chg    <= r_chg;
                        r_o_txv    <= r_txv;
                        r_o_txid   <= r_txid;
                        r_o_txlen  <= r_txlen;
                        r_o_txdata <= r_txdata;
                        r_o_rv     <= r_rv;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_accepted   = r_o_acc;
    assign o_changed    = r_o_chg;
    assign o_tx_valid   = r_o_txv;
    assign o_tx_id      = r_o_txid;
    assign o_tx_len     = r_o_txlen;
    assign o_tx_data    = r_o_txdata;
    assign o_read_value = r_o_rv;

`ifndef NO_ASSERTIONS
    a_tx_needs_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_txv) |-> r_o_acc)
        else $error("reply built for a frame that was not accepted");

    a_len_needs_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_txlen != '0) |-> r_o_txv)
        else $error("reply length set without a reply");

    a_rv_local: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_rv != '0) |-> (!r_o_acc && !r_o_txv && !r_o_chg))
        else $error("read value on a request that is not a local read");

    a_we_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rf_req.we |-> (r_state == S_EXEC))
        else $error("register write outside the execute step");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for can_register_node_responder: directed and random requests against a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] REQ_NONE   = 2'd3;
    localparam int         IDLE_LIMIT = 4000;
    localparam int         HOLD_LEN   = 300;
    localparam int         HOLD_AT    = 600;

    typedef struct packed {
        logic [1:0]                  kind;
        logic [crnr_pkg::ID_W-1:0]   id;
        logic [crnr_pkg::LEN_W-1:0]  len;
        logic [crnr_pkg::DATA_W-1:0] data;
        logic [crnr_pkg::IDX_W-1:0]  lidx;
        logic [crnr_pkg::REG_W-1:0]  lval;
    } t_node_req;

    typedef struct packed {
        logic                           accepted;
        logic                           changed;
        logic                           tx_valid;
        logic [crnr_pkg::ID_W-1:0]      tx_id;
        logic [crnr_pkg::TX_LEN_W-1:0]  tx_len;
        logic [crnr_pkg::TX_DATA_W-1:0] tx_data;
        logic [crnr_pkg::REG_W-1:0]     read_value;
    } t_node_rsp;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_we      = 1'b0;
    logic [1:0]                     i_cfg_idx     = '0;
    logic [7:0]                     i_cfg_data    = '0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_ready;
    logic [1:0]                     i_req_type    = '0;
    logic [crnr_pkg::ID_W-1:0]      i_frame_id    = '0;
    logic [crnr_pkg::LEN_W-1:0]     i_frame_len   = '0;
    logic [crnr_pkg::DATA_W-1:0]    i_frame_data  = '0;
    logic [crnr_pkg::IDX_W-1:0]     i_local_index = '0;
    logic [crnr_pkg::REG_W-1:0]     i_local_value = '0;
    logic                           o_out_valid;
    logic                           i_out_ready   = 1'b0;
    logic                           o_accepted;
    logic                           o_changed;
    logic                           o_tx_valid;
    logic [crnr_pkg::ID_W-1:0]      o_tx_id;
    logic [crnr_pkg::TX_LEN_W-1:0]  o_tx_len;
    logic [crnr_pkg::TX_DATA_W-1:0] o_tx_data;
    logic [crnr_pkg::REG_W-1:0]     o_read_value;

    can_register_node_responder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_frame_id    (i_frame_id),
        .i_frame_len   (i_frame_len),
        .i_frame_data  (i_frame_data),
        .i_local_index (i_local_index),
        .i_local_value (i_local_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_accepted    (o_accepted),
        .o_changed     (o_changed),
        .o_tx_valid    (o_tx_valid),
        .o_tx_id       (o_tx_id),
        .o_tx_len      (o_tx_len),
        .o_tx_data     (o_tx_data),
        .o_read_value  (o_read_value)
    );

    always #6 i_clk = ~i_clk;

    // predictor state and node settings
    logic [crnr_pkg::REG_W-1:0]   node_regs   [crnr_pkg::NUM_REGS];
    logic [crnr_pkg::REG_W-1:0]   frame_bytes [8];
    logic [crnr_pkg::EXTRA_W-1:0] act_idx;
    logic [crnr_pkg::ADDR_W-1:0]  peer_addr;
    logic [crnr_pkg::ADDR_W-1:0]  cfg_my_addr;
    logic [crnr_pkg::EXTRA_W-1:0] cfg_extra;
    logic [crnr_pkg::ADDR_W-1:0]  cfg_bcast;

    t_node_req pending_q[$];
    t_node_rsp reply_q[$];
    t_node_req cur_req;
    bit        offering   = 1'b0;
    bit        no_idle    = 1'b0;
    bit        hold_done  = 1'b0;
    int        gap_left   = 0;
    int        stall_left = 0;
    int        hold_left  = 0;
    int        sent_cnt   = 0;
    int        got_cnt    = 0;
    int        err_cnt    = 0;
    int        cfg_cnt    = 0;
    int        idle_cnt   = 0;

    function automatic logic [crnr_pkg::TX_DATA_W-1:0] regs_word();
        logic [crnr_pkg::TX_DATA_W-1:0] w;
        int i;
        w = '0;
        for (i = 0; i < int'(crnr_pkg::NUM_TX_REG); i++)
            w[8*i +: 8] = node_regs[i];
        return w;
    endfunction

    function automatic t_node_rsp node_reply(input t_node_req r);
        t_node_rsp o;
        logic [7:0] snd, rcv, pay, off, me;
        logic [1:0] op;
        logic [2:0] rg;
        int i, n;
        o = '0;
        case (r.kind)
            crnr_pkg::REQ_WRITE: begin
                o.changed = (node_regs[r.lidx] != r.lval);
                node_regs[r.lidx] = r.lval;
            end
            crnr_pkg::REQ_READ: begin
                o.read_value = node_regs[r.lidx];
            end
            crnr_pkg::REQ_FRAME: begin
                snd = r.id[28:21];
                rcv = r.id[20:13];
                op  = r.id[12:11];
                rg  = r.id[10:8];
                pay = r.id[7:0];
                off = rcv - cfg_my_addr;
                if (snd == cfg_bcast || off <= {6'd0, cfg_extra}) begin
                    o.accepted = 1'b1;
                    n = (r.len > 4'd8) ? 8 : int'(r.len);
                    for (i = 0; i < n; i++)
                        frame_bytes[i] = r.data[8*i +: 8];
                    act_idx   = (off > {6'd0, cfg_extra}) ? cfg_extra : off[1:0];
                    peer_addr = snd;
                    me        = cfg_my_addr + {6'd0, act_idx};
                    if (op == crnr_pkg::OP_WRITE || op == crnr_pkg::OP_WRITE_ACK) begin
                        if (rg == crnr_pkg::MULTI_REG) begin
                            for (i = 0; i < int'(crnr_pkg::NUM_TX_REG); i++) begin
                                if (pay[i]) begin
                                    if (node_regs[i] != frame_bytes[i])
                                        o.changed = 1'b1;
                                    node_regs[i] = frame_bytes[i];
                                end
                            end
                        end else begin
                            o.changed = (node_regs[rg] != pay);
                            node_regs[rg] = pay;
                        end
                        if (op == crnr_pkg::OP_WRITE_ACK) begin
                            o.tx_valid = 1'b1;
                            if (rg == crnr_pkg::MULTI_REG) begin
                                o.tx_id   = {me, peer_addr, crnr_pkg::OP_ACK, rg, pay};
                                o.tx_len  = crnr_pkg::TX_LEN_MUL;
                                o.tx_data = regs_word();
                            end else begin
                                o.tx_id = {me, peer_addr, crnr_pkg::OP_ACK, rg, node_regs[rg]};
                            end
                        end
                    end else if (op == crnr_pkg::OP_READ) begin
                        o.tx_valid = 1'b1;
                        if (rg == crnr_pkg::MULTI_REG) begin
                            o.tx_id   = {me, peer_addr, crnr_pkg::OP_ACK, crnr_pkg::MULTI_REG,
                                         crnr_pkg::PAY_ALL};
                            o.tx_len  = crnr_pkg::TX_LEN_MUL;
                            o.tx_data = regs_word();
                        end else begin
                            o.tx_id = {me, peer_addr, crnr_pkg::OP_ACK, rg, node_regs[rg]};
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic int pick_idle();
        int k;
        k = $urandom_range(0, 99);
        if (no_idle || k < 60)
            return 0;
        else if (k < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic t_node_req frame_req(input logic [7:0] snd, input logic [7:0] rcv,
                                            input logic [1:0] op, input logic [2:0] rg,
                                            input logic [7:0] pay, input logic [3:0] len,
                                            input logic [63:0] data);
        t_node_req r;
        r      = '0;
        r.kind = crnr_pkg::REQ_FRAME;
        r.id   = {snd, rcv, op, rg, pay};
        r.len  = len;
        r.data = data;
        return r;
    endfunction

    function automatic t_node_req local_req(input logic [1:0] kind, input logic [2:0] idx,
                                            input logic [7:0] val);
        t_node_req r;
        r      = '0;
        r.kind = kind;
        r.lidx = idx;
        r.lval = val;
        return r;
    endfunction

    function automatic t_node_req rand_request();
        t_node_req r;
        logic [31:0] w;
        int k, m;
        w      = $urandom;
        r.id   = w[crnr_pkg::ID_W-1:0];
        r.len  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                             : 4'($urandom_range(0, 8));
        r.data = {$urandom, $urandom};
        r.lidx = 3'($urandom_range(0, 7));
        r.lval = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 1)) : 8'($urandom);
        k = $urandom_range(0, 99);
        if (k < 12) begin
            r.kind = crnr_pkg::REQ_WRITE;
        end else if (k < 22) begin
            r.kind = crnr_pkg::REQ_READ;
        end else if (k < 25) begin
            r.kind = REQ_NONE;
        end else begin
            r.kind = crnr_pkg::REQ_FRAME;
            m = $urandom_range(0, 9);
            if (m < 7)
                r.id[20:13] = cfg_my_addr + 8'($urandom_range(0, cfg_extra));
            else if (m < 9)
                r.id[28:21] = cfg_bcast;
            if ($urandom_range(0, 2) == 0)
                r.id[10:8] = crnr_pkg::MULTI_REG;
        end
        return r;
    endfunction

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
    endtask

    task automatic set_config(input logic [7:0] my, input logic [1:0] extra,
                              input logic [7:0] bcast);
        cfg_write(crnr_pkg::CFG_MY_ADDR, my);
        cfg_write(crnr_pkg::CFG_EXTRA, {6'd0, extra});
        cfg_write(crnr_pkg::CFG_BCAST, bcast);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_my_addr = my;
        cfg_extra   = extra;
        cfg_bcast   = bcast;
        cfg_cnt++;
    endtask

    task automatic load_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            pending_q.push_back(rand_request());
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || offering || reply_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (offering && o_in_ready) begin
                reply_q.push_back(node_reply(cur_req));
                sent_cnt++;
                offering = 1'b0;
                gap_left = pick_idle();
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_q.size() != 0) begin
                    cur_req  = pending_q.pop_front();
                    offering = 1'b1;
                end
            end
            i_in_valid    <= offering;
            i_req_type    <= cur_req.kind;
            i_frame_id    <= cur_req.id;
            i_frame_len   <= cur_req.len;
            i_frame_data  <= cur_req.data;
            i_local_index <= cur_req.lidx;
            i_local_value <= cur_req.lval;
        end
    end

    // reply monitor
    always @(posedge i_clk) begin
        t_node_rsp want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got_cnt++;
                if (reply_q.size() == 0) begin
                    $display("%0t: reply with no request outstanding", $time);
                    err_cnt++;
                end else begin
                    want = reply_q.pop_front();
                    check_field("accepted", 64'(want.accepted), 64'(o_accepted));
                    check_field("changed", 64'(want.changed), 64'(o_changed));
                    check_field("tx_valid", 64'(want.tx_valid), 64'(o_tx_valid));
                    check_field("tx_id", 64'(want.tx_id), 64'(o_tx_id));
                    check_field("tx_len", 64'(want.tx_len), 64'(o_tx_len));
                    check_field("tx_data", 64'(want.tx_data), 64'(o_tx_data));
                    check_field("read_value", 64'(want.read_value), 64'(o_read_value));
                end
            end
            // one long back-pressure window to fill the block
            if (!hold_done && got_cnt >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_idle();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cnt = 0;
        else
            idle_cnt++;
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int k;
        for (k = 0; k < int'(crnr_pkg::NUM_REGS); k++) begin
            node_regs[k]   = '0;
            frame_bytes[k] = '0;
        end
        act_idx     = '0;
        peer_addr   = '0;
        cfg_my_addr = '0;
        cfg_extra   = '0;
        cfg_bcast   = '0;
        cur_req     = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_config(8'h10, 2'd3, 8'h80);
        pending_q.push_back(local_req(crnr_pkg::REQ_WRITE, 3'd0, 8'hFF));
        pending_q.push_back(local_req(crnr_pkg::REQ_WRITE, 3'd0, 8'hFF));
        pending_q.push_back(local_req(crnr_pkg::REQ_READ, 3'd0, 8'h00));
        pending_q.push_back(local_req(crnr_pkg::REQ_WRITE, 3'd7, 8'hA5));
        pending_q.push_back(local_req(crnr_pkg::REQ_READ, 3'd7, 8'h00));
        pending_q.push_back('1);
        pending_q.push_back(frame_req(8'h33, 8'h10, crnr_pkg::OP_WRITE, 3'd2, 8'h5A, 4'd8,
                                      64'h0123_4567_89AB_CDEF));
        pending_q.push_back(frame_req(8'h33, 8'h13, crnr_pkg::OP_WRITE_ACK, 3'd3, 8'h00,
                                      4'd0, '0));
        pending_q.push_back(frame_req(8'h44, 8'h12, crnr_pkg::OP_WRITE_ACK,
                                      crnr_pkg::MULTI_REG, 8'h7F, 4'd8, '1));
        pending_q.push_back(frame_req(8'h44, 8'h11, crnr_pkg::OP_WRITE, crnr_pkg::MULTI_REG,
                                      8'h80, 4'd0, '0));
        pending_q.push_back(frame_req(8'h44, 8'h10, crnr_pkg::OP_READ, 3'd2, 8'h00, 4'd0,
                                      '0));
        pending_q.push_back(frame_req(8'h44, 8'h10, crnr_pkg::OP_READ, crnr_pkg::MULTI_REG,
                                      8'h00, 4'd0, '0));
        pending_q.push_back(frame_req(8'h44, 8'h10, crnr_pkg::OP_ACK, 3'd1, 8'h12, 4'd4,
                                      64'hFEDC_BA98_7654_3210));
        pending_q.push_back(frame_req(8'h44, 8'h14, crnr_pkg::OP_WRITE, 3'd1, 8'h99, 4'd8,
                                      64'h1111_2222_3333_4444));
        pending_q.push_back(frame_req(8'h80, 8'hF0, crnr_pkg::OP_READ, 3'd0, 8'h00, 4'd15,
                                      64'hAAAA_5555_AAAA_5555));
        pending_q.push_back(frame_req(8'h80, 8'h0F, crnr_pkg::OP_WRITE_ACK,
                                      crnr_pkg::MULTI_REG, 8'hFF, 4'd3,
                                      64'h0F0E_0D0C_0B0A_0908));
        pending_q.push_back(frame_req(8'hFF, 8'hFF, crnr_pkg::OP_ACK, crnr_pkg::MULTI_REG,
                                      8'hFF, 4'd15, '1));
        pending_q.push_back(frame_req(8'h00, 8'h00, crnr_pkg::OP_WRITE, 3'd0, 8'h00, 4'd0,
                                      '0));
        pending_q.push_back(local_req(crnr_pkg::REQ_READ, 3'd3, 8'h00));
        pending_q.push_back(local_req(crnr_pkg::REQ_WRITE, 3'd6, 8'h00));
        wait_drained();

        // address range wrapping past 0xFF
        set_config(8'hFF, 2'd3, 8'h00);
        load_random(300);
        wait_drained();

        set_config(8'h00, 2'd0, 8'hFF);
        load_random(300);
        wait_drained();

        for (k = 0; k < 4; k++) begin
            set_config(8'($urandom), 2'($urandom_range(0, 3)), 8'($urandom));
            no_idle = (k == 1);
            load_random(300);
            wait_drained();
        end
        no_idle = 1'b0;

        $display("Summary: %0d requests sent, %0d replies checked, %0d node settings",
                 sent_cnt, got_cnt, cfg_cnt);
        $display("Summary: %0d mismatches found", err_cnt);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
